// ----- hdl/sidst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidst_pkg
// Shared types and constants of the screen idle / dim / sleep timer.
// ----------------------------------------------------------------------------
package sidst_pkg;

  // Clock limits
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  // Dimming and keep-on
  localparam int unsigned SLEEP_AFTER_DIM = 5;
  localparam int unsigned KEEP_ON_BITS    = 8;
  localparam int unsigned DIM_W           = 3;
  localparam logic [DIM_W-1:0] DIM_SLEEP  = DIM_W'(SLEEP_AFTER_DIM);
  localparam logic [7:0] DIM_LOW          = 8'd1;
  localparam logic [7:0] DIM_HIGH         = 8'd5;
  localparam logic [15:0] REST_MIN        = 16'd3;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

  // Reset values
  localparam logic [7:0]  USER_BRIGHTNESS_RST = 8'd50;
  localparam logic [15:0] REST_SECONDS_RST    = 16'd30;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_USER_BRIGHTNESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REST_SECONDS    = 2'd1;

  // Stream widths
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [2:0] {
    CMD_SECOND   = 3'd0,
    CMD_RAMP     = 3'd1,
    CMD_ACTIVITY = 3'd2,
    CMD_KEEP_ON  = 3'd3,
    CMD_KEEP_OFF = 3'd4,
    CMD_LOAD     = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       usb_online;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  // Packed with hour in the lowest bits
  typedef struct packed {
    logic       resync_request;
    logic       sleep_request;
    logic       dimmed;
    logic [7:0] level_out;
    logic [7:0] target_out;
    logic [5:0] second_out;
    logic [5:0] minute_out;
    logic [4:0] hour_out;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ----- hdl/sidst_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidst_core
// Holds clock, idle, dimming and backlight state; updates it for one
// accepted transaction per cycle and forms the result of that transaction.
// ----------------------------------------------------------------------------
module sidst_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  sidst_pkg::item_t     item,
  input  sidst_pkg::cfg_write_t cfg,
  output sidst_pkg::result_t   result
);

  logic [7:0]  user_brightness, user_brightness_next;
  logic [15:0] rest_seconds, rest_seconds_next;
  logic [5:0]  seconds, seconds_next;
  logic [5:0]  minutes, minutes_next;
  logic [4:0]  hours, hours_next;
  logic [15:0] idle_count, idle_count_next;
  logic        last_usb, last_usb_next;
  logic [sidst_pkg::DIM_W-1:0] dim_ticks, dim_ticks_next;
  logic [7:0]  target_level, target_level_next;
  logic [7:0]  backlight_level, backlight_level_next;
  logic [sidst_pkg::KEEP_ON_BITS-1:0] keep_on_depth, keep_on_depth_next;
  logic        sleep_pulse, resync_pulse;
  logic [15:0] idle_base;
  logic [7:0]  cfg_bright;

  // Idle count after the USB check and the saturating increment
  always_comb begin
    idle_base = (item.usb_online != last_usb) ? 16'd0 : idle_count;
    if (idle_base != sidst_pkg::IDLE_MAX) begin
      idle_base = idle_base + 16'd1;
    end
  end

  // Next state for the accepted transaction or configuration write
  always_comb begin
    user_brightness_next = user_brightness;
    rest_seconds_next    = rest_seconds;
    seconds_next         = seconds;
    minutes_next         = minutes;
    hours_next           = hours;
    idle_count_next      = idle_count;
    last_usb_next        = last_usb;
    dim_ticks_next       = dim_ticks;
    target_level_next    = target_level;
    backlight_level_next = backlight_level;
    keep_on_depth_next   = keep_on_depth;
    sleep_pulse          = 1'b0;
    resync_pulse         = 1'b0;
    cfg_bright           = cfg.data[7:0];

    if (in_fire) begin
      unique case (item.command)
        sidst_pkg::CMD_SECOND: begin
          // advance time of day
          if (seconds >= sidst_pkg::SEC_LAST) begin
            seconds_next = 6'd0;
            if (minutes >= sidst_pkg::MIN_LAST) begin
              minutes_next = 6'd0;
              if (hours >= sidst_pkg::HOUR_LAST) begin
                hours_next   = 5'd0;
                resync_pulse = 1'b1;
              end else begin
                hours_next = hours + 5'd1;
              end
            end else begin
              minutes_next = minutes + 6'd1;
            end
          end else begin
            seconds_next = seconds + 6'd1;
          end
          // idle tracking and dimming
          last_usb_next   = item.usb_online;
          idle_count_next = idle_base;
          if ((keep_on_depth == '0) && (idle_base >= rest_seconds)) begin
            if (dim_ticks == '0) begin
              target_level_next = (user_brightness < sidst_pkg::DIM_HIGH) ?
                                  sidst_pkg::DIM_LOW : sidst_pkg::DIM_HIGH;
            end
            if (dim_ticks < sidst_pkg::DIM_SLEEP) begin
              dim_ticks_next = dim_ticks + 1'b1;
              sleep_pulse    = (dim_ticks_next == sidst_pkg::DIM_SLEEP);
            end
          end else begin
            if (dim_ticks != '0) begin
              target_level_next = user_brightness;
            end
            dim_ticks_next = '0;
          end
        end
        sidst_pkg::CMD_RAMP: begin
          // step the backlight toward the target
          if (backlight_level < target_level) begin
            backlight_level_next = backlight_level + 8'd1;
          end else if (backlight_level > target_level) begin
            backlight_level_next = backlight_level - 8'd1;
          end
        end
        sidst_pkg::CMD_ACTIVITY: begin
          idle_count_next = 16'd0;
        end
        sidst_pkg::CMD_KEEP_ON: begin
          if (keep_on_depth == '0) begin
            keep_on_depth_next = {{(sidst_pkg::KEEP_ON_BITS-1){1'b0}}, 1'b1};
            idle_count_next    = 16'd0;
          end else if (keep_on_depth != '1) begin
            keep_on_depth_next = keep_on_depth + 1'b1;
          end
        end
        sidst_pkg::CMD_KEEP_OFF: begin
          if (keep_on_depth > {{(sidst_pkg::KEEP_ON_BITS-1){1'b0}}, 1'b1}) begin
            keep_on_depth_next = keep_on_depth - 1'b1;
          end else if (keep_on_depth != '0) begin
            keep_on_depth_next = '0;
            idle_count_next    = 16'd0;
          end
        end
        sidst_pkg::CMD_LOAD: begin
          // load time, clamping each field
          hours_next   = (item.hour_in > sidst_pkg::HOUR_LAST) ?
                         sidst_pkg::HOUR_LAST : item.hour_in;
          minutes_next = (item.minute_in > sidst_pkg::MIN_LAST) ?
                         sidst_pkg::MIN_LAST : item.minute_in;
          seconds_next = (item.second_in > sidst_pkg::SEC_LAST) ?
                         sidst_pkg::SEC_LAST : item.second_in;
        end
        default: begin
        end
      endcase
    end

    // Apply configuration writes
    if (cfg.valid) begin
      if (cfg.index == sidst_pkg::CFG_USER_BRIGHTNESS) begin
        if (cfg_bright == 8'd0) begin
          cfg_bright = 8'd1;
        end
        user_brightness_next = cfg_bright;
        target_level_next    = cfg_bright;
      end else if (cfg.index == sidst_pkg::CFG_REST_SECONDS) begin
        if (cfg.data >= sidst_pkg::REST_MIN) begin
          rest_seconds_next = cfg.data;
          idle_count_next   = 16'd0;
        end
      end
    end
  end

  // Form the result from the updated state
  always_comb begin
    result.hour_out       = hours_next;
    result.minute_out     = minutes_next;
    result.second_out     = seconds_next;
    result.target_out     = target_level_next;
    result.level_out      = backlight_level_next;
    result.dimmed         = (dim_ticks_next != '0);
    result.sleep_request  = sleep_pulse;
    result.resync_request = resync_pulse;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      user_brightness <= sidst_pkg::USER_BRIGHTNESS_RST;
      rest_seconds    <= sidst_pkg::REST_SECONDS_RST;
      seconds         <= '0;
      minutes         <= '0;
      hours           <= '0;
      idle_count      <= '0;
      last_usb        <= 1'b0;
      dim_ticks       <= '0;
      target_level    <= sidst_pkg::USER_BRIGHTNESS_RST;
      backlight_level <= '0;
      keep_on_depth   <= '0;
    end else begin
      user_brightness <= user_brightness_next;
      rest_seconds    <= rest_seconds_next;
      seconds         <= seconds_next;
      minutes         <= minutes_next;
      hours           <= hours_next;
      idle_count      <= idle_count_next;
      last_usb        <= last_usb_next;
      dim_ticks       <= dim_ticks_next;
      target_level    <= target_level_next;
      backlight_level <= backlight_level_next;
      keep_on_depth   <= keep_on_depth_next;
    end
  end

  // Dim counter never runs past the sleep point
  assert property (@(posedge clk) disable iff (rst)
    dim_ticks <= sidst_pkg::DIM_SLEEP)
    else $error("dim_ticks beyond sleep point");

  // Sleep request only on the step into the sleep point
  assert property (@(posedge clk) disable iff (rst)
    result.sleep_request |=> dim_ticks == sidst_pkg::DIM_SLEEP && $past(dim_ticks) ==
      sidst_pkg::DIM_SLEEP - 1'b1)
    else $error("sleep request without reaching sleep point");

  // A second tick at 23:59:59 wraps to midnight and requests resync
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg.valid && item.command == sidst_pkg::CMD_SECOND &&
    hours == sidst_pkg::HOUR_LAST && minutes == sidst_pkg::MIN_LAST &&
    seconds == sidst_pkg::SEC_LAST
    |=> hours == 5'd0 && minutes == 6'd0 && seconds == 6'd0 && $past(result.resync_request))
    else $error("midnight wrap missed");

  // A held keep-on request keeps the screen undimmed after a second tick
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg.valid && item.command == sidst_pkg::CMD_SECOND && keep_on_depth != '0
    |=> dim_ticks == '0)
    else $error("dimmed while keep-on held");

endmodule

// ----- hdl/sidst_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidst_skid
// Two-entry result buffer between the core and the master stream port.
// ----------------------------------------------------------------------------
module sidst_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sidst_pkg::result_t push_data,
  output logic               ready,
  output logic               valid,
  input  logic               pop_ready,
  output sidst_pkg::result_t data
);

  sidst_pkg::result_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign pop   = valid && pop_ready;
  assign data  = entry[rd_ptr];

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Occupancy stays within the two entries
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("skid occupancy overflow");

  // Never push into a full buffer
  assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("push while full");

  // Pointers differ exactly when one entry is held
  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr != rd_ptr) == (count == 2'd1))
    else $error("skid pointers inconsistent");

endmodule

// ----- hdl/screen_idle_dim_sleep_timer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_idle_dim_sleep_timer_unit
// Time-of-day clock with idle dimming, sleep request and backlight ramp.
// ----------------------------------------------------------------------------
// Each result is registered in the result buffer before it appears on the master port.
// Throughput: one transaction per cycle while the result buffer is not full.
// The two-entry result buffer keeps input open while one result waits.
// Reset (rst, synchronous): clock 0:00:00, idle and dim counters cleared,
// brightness 50, rest time 30 s, backlight 0, result buffer empty.
module screen_idle_dim_sleep_timer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // usb_online, hour_in, minute_in, second_in, zero fill
  input  logic [sidst_pkg::S_TDATA_W-1:0]   s_tdata,
  // command
  input  logic [sidst_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hour_out, minute_out, second_out, target_out, level_out, dimmed,
  // sleep_request, resync_request, zero fill
  output logic [sidst_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sidst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sidst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sidst_pkg::item_t      item;
  sidst_pkg::cfg_write_t cfg;
  sidst_pkg::result_t    core_result;
  sidst_pkg::result_t    out_result;
  logic                  in_fire;

  // Unpack the input transaction
  assign in_fire         = s_tvalid && s_tready;
  assign item.command    = sidst_pkg::cmd_t'(s_tuser);
  assign item.usb_online = s_tdata[0];
  assign item.hour_in    = s_tdata[5:1];
  assign item.minute_in  = s_tdata[11:6];
  assign item.second_in  = s_tdata[17:12];

  // Configuration is always accepted
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sidst_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .item    (item),
    .cfg     (cfg),
    .result  (core_result)
  );

  sidst_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (core_result),
    .ready     (s_tready),
    .valid     (m_tvalid),
    .pop_ready (m_tready),
    .data      (out_result)
  );

  // Pack the result transaction
  assign m_tdata = {(sidst_pkg::M_TDATA_W - sidst_pkg::RESULT_W)'(0), out_result};

endmodule
